@@ sv/scs_pkg.sv @@
// Shared types and constants for the sprite collision scan unit.
package scs_pkg;

  localparam int NUM_SLOTS_DEF = 16;

  localparam int SLOT_W   = 4;
  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 8;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic [RADIUS_W-1:0]        hit_radius;
    logic                       active;
  } scs_in_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
  } scs_out_t;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RADIUS_W-1:0]       r;
  } scs_ent_t;

  localparam int ENT_W = $bits(scs_ent_t);

endpackage

@@ sv/scs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sprite_collision_scan_unit.sv @@
// Sprite collision scan unit: slot table in RAM, one-entry-per-cycle collision scan.
//
// The unit keeps NUM_SLOTS sprite slots (position, hit radius, active flag).
// A write transfer loads one slot and gives no result; it is taken whenever
// the unit is idle, even while an earlier result still waits on the output.
// A query transfer names a slot and always gives one result: no hit when the
// slot is out of range or inactive, otherwise the lowest-index other active
// slot that lies within the summed radii. Position and radius live in one
// RAM with a registered read; only the active flags are flip-flops, cleared
// at reset, so no clearing pass is needed. A query of an active slot that
// finds nothing raises out_valid after the query-slot read and its load, one
// RAM read per slot, two stages for distances and squares, the last compare
// and a check that the pipeline is empty, and the result hand-off. A hit
// stops the scan early. An inactive or out-of-range query skips the scan and
// goes straight to the result hand-off. The input stalls while a query is
// being worked on and while a finished answer waits behind a full output
// register; a query holds it off for its whole scan, paced one slot at a
// time by the single read port of the slot RAM, so no new transfer is taken
// until the previous answer has been handed off.
module sprite_collision_scan_unit
  import scs_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  scs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output scs_out_t out_data
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int RCH_W = RADIUS_W + 1;      // sum of two radii
  localparam int DST_W = COORD_W + 1;       // full coordinate difference
  localparam int SQ_W  = 2 * RCH_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic                 in_xfer, out_xfer;
  logic [EXT_W-1:0]     in_slot_ext;
  logic [IDX_W-1:0]     in_idx;
  logic                 in_slot_ok;

  logic [NUM_SLOTS-1:0] act_r;
  logic [IDX_W-1:0]     q_idx_r;
  scs_ent_t             q_ent_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 issue;

  // RAM
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  scs_ent_t             ram_wdata, ram_rdata;

  // pipeline: p0 = entry in RAM read data, p1 = distances, p2 = squares
  logic                 p0_v_r, p0_en_r;
  logic [IDX_W-1:0]     p0_idx_r;
  logic                 p1_v_r, p1_en_r;
  logic [IDX_W-1:0]     p1_idx_r;
  logic [RCH_W-1:0]     p1_dx_r, p1_dy_r, p1_rch_r;
  logic                 p2_v_r, p2_en_r;
  logic [IDX_W-1:0]     p2_idx_r;
  logic [SQ_W-1:0]      p2_sx_r, p2_sy_r, p2_rr_r;

  logic signed [DST_W-1:0] dx_s, dy_s;
  logic [DST_W-1:0]        dx_a, dy_a;
  logic [RCH_W-1:0]        rch;
  logic                    near;
  logic [SQ_W:0]           sq_sum;
  logic                    p2_hit;
  logic                    scan_end;
  logic [EXT_W-1:0]        hit_ext;

  logic                    res_hit_r;
  logic [SLOT_W-1:0]       res_slot_r;
  logic                    out_valid_r;
  scs_out_t                out_data_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_xfer  = out_valid_r && !out_stall;

  assign in_slot_ext = EXT_W'(in_data.slot);
  assign in_idx      = in_slot_ext[IDX_W-1:0];
  assign in_slot_ok  = (32'(in_data.slot) < NUM_SLOTS);

  // table write
  assign ram_we          = in_xfer && (in_data.req_type == REQ_WRITE) && in_slot_ok;
  assign ram_wdata.x     = in_data.pos_x;
  assign ram_wdata.y     = in_data.pos_y;
  assign ram_wdata.r     = in_data.hit_radius;
  // idle: fetch the queried slot; scanning: fetch the slot under the counter
  assign ram_raddr = (state_r == ST_IDLE) ? in_idx : cnt_r[IDX_W-1:0];

  scs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign issue = (state_r == ST_SCAN) && (cnt_r < CNT_W'(NUM_SLOTS));

  // stage 1: exact axis distances and the bounding-box test
  always_comb begin
    dx_s = DST_W'(ram_rdata.x) - DST_W'(q_ent_r.x);
    dy_s = DST_W'(ram_rdata.y) - DST_W'(q_ent_r.y);
    dx_a = dx_s[DST_W-1] ? DST_W'(-dx_s) : DST_W'(dx_s);
    dy_a = dy_s[DST_W-1] ? DST_W'(-dy_s) : DST_W'(dy_s);
    rch  = RCH_W'(ram_rdata.r) + RCH_W'(q_ent_r.r);
    near = (dx_a <= DST_W'(rch)) && (dy_a <= DST_W'(rch));
  end

  // stage 3: circle test
  assign sq_sum   = (SQ_W + 1)'(p2_sx_r) + (SQ_W + 1)'(p2_sy_r);
  assign p2_hit   = p2_v_r && p2_en_r && (sq_sum <= (SQ_W + 1)'(p2_rr_r));
  assign scan_end = !issue && !p0_v_r && !p1_v_r && !p2_v_r;
  assign hit_ext  = EXT_W'(p2_idx_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_data.req_type == REQ_QUERY)) begin
          state_nxt = (in_slot_ok && act_r[in_idx]) ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (p2_hit || scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_xfer) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      act_r       <= '0;
      p0_v_r      <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        act_r[in_idx] <= in_data.active;
      end
      if (state_r == ST_LOAD) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      // a hit drops whatever is still in flight behind it
      p0_v_r <= issue && !p2_hit;
      p1_v_r <= p0_v_r && !p2_hit;
      p2_v_r <= p1_v_r && !p2_hit;
      if (state_r == ST_DONE && (!out_valid_r || out_xfer)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_idx_r <= in_idx;
    end
    if (state_r == ST_LOAD) begin
      q_ent_r <= ram_rdata;
    end

    p0_idx_r <= cnt_r[IDX_W-1:0];
    p0_en_r  <= act_r[cnt_r[IDX_W-1:0]] && (cnt_r[IDX_W-1:0] != q_idx_r);

    p1_idx_r <= p0_idx_r;
    p1_en_r  <= p0_en_r && near;
    p1_dx_r  <= dx_a[RCH_W-1:0];
    p1_dy_r  <= dy_a[RCH_W-1:0];
    p1_rch_r <= rch;

    p2_idx_r <= p1_idx_r;
    p2_en_r  <= p1_en_r;
    p2_sx_r  <= SQ_W'(p1_dx_r) * SQ_W'(p1_dx_r);
    p2_sy_r  <= SQ_W'(p1_dy_r) * SQ_W'(p1_dy_r);
    p2_rr_r  <= SQ_W'(p1_rch_r) * SQ_W'(p1_rch_r);

    if (state_r == ST_IDLE) begin
      res_hit_r  <= 1'b0;
      res_slot_r <= '0;
    end else if (state_r == ST_SCAN && p2_hit) begin
      res_hit_r  <= 1'b1;
      res_slot_r <= hit_ext[SLOT_W-1:0];
    end

    if (state_r == ST_DONE && (!out_valid_r || out_xfer)) begin
      out_data_r.hit      <= res_hit_r;
      out_data_r.hit_slot <= res_slot_r;
    end
  end

endmodule

@@ tb/sv/scs_tb_pkg.sv @@
// Collision scoreboard: slot table predictor and queue of answers still owed by the unit.
`timescale 1ns / 1ps

package scs_tb_pkg;
  import scs_pkg::*;

  class collision_scoreboard;
    // predictor's own copy of the slot table
    logic signed [COORD_W-1:0] x_tab [NUM_SLOTS_DEF];
    logic signed [COORD_W-1:0] y_tab [NUM_SLOTS_DEF];
    logic [RADIUS_W-1:0]       r_tab [NUM_SLOTS_DEF];
    bit                        on_tab [NUM_SLOTS_DEF];

    scs_out_t    pending_answers [$];
    int unsigned n_fail;
    int unsigned n_write;
    int unsigned n_query;
    int unsigned n_hit;
    int unsigned n_checked;

    function new();
      foreach (on_tab[i]) begin
        on_tab[i] = 1'b0;
      end
      n_fail    = 0;
      n_write   = 0;
      n_query   = 0;
      n_hit     = 0;
      n_checked = 0;
    endfunction

    // exact distances, 32-bit int differences, no wrap
    function bit circles_touch(int a, int b);
      int     xa, xb, ya, yb, dx, dy, reach;
      longint d2;
      xa = x_tab[a];
      xb = x_tab[b];
      ya = y_tab[a];
      yb = y_tab[b];
      dx = (xa >= xb) ? xa - xb : xb - xa;
      dy = (ya >= yb) ? ya - yb : yb - ya;
      reach = int'(r_tab[a]) + int'(r_tab[b]);
      if (dx > reach || dy > reach) begin
        return 1'b0;
      end
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      return d2 <= longint'(reach) * reach;
    endfunction

    function scs_out_t predict_answer(int s);
      scs_out_t ans;
      ans = '0;
      if (s >= NUM_SLOTS_DEF || !on_tab[s]) begin
        return ans;
      end
      for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
        if (i != s && on_tab[i] && circles_touch(i, s)) begin
          ans.hit      = 1'b1;
          ans.hit_slot = SLOT_W'(i);
          break;
        end
      end
      return ans;
    endfunction

    // called once per accepted input transfer
    function void note_transfer(scs_in_t it);
      scs_out_t ans;
      if (it.req_type == REQ_WRITE) begin
        n_write++;
        if (int'(it.slot) < NUM_SLOTS_DEF) begin
          x_tab[it.slot]  = it.pos_x;
          y_tab[it.slot]  = it.pos_y;
          r_tab[it.slot]  = it.hit_radius;
          on_tab[it.slot] = it.active;
        end
      end else begin
        n_query++;
        ans = predict_answer(int'(it.slot));
        if (ans.hit) begin
          n_hit++;
        end
        pending_answers.push_back(ans);
      end
    endfunction

    task report(string msg);
      n_fail++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // called once per accepted result transfer
    task check_answer(scs_out_t got);
      scs_out_t want;
      if (pending_answers.size() == 0) begin
        report($sformatf("answer with none owed: hit=%0b slot=%0d", got.hit, got.hit_slot));
        return;
      end
      want = pending_answers.pop_front();
      n_checked++;
      if (got.hit !== want.hit) begin
        report($sformatf("answer %0d hit: got %b, want %b", n_checked, got.hit, want.hit));
      end
      if (got.hit_slot !== want.hit_slot) begin
        report($sformatf("answer %0d hit_slot: got %0d, want %0d",
                         n_checked, got.hit_slot, want.hit_slot));
      end
    endtask
  endclass

endpackage

@@ tb/sv/tb_top.sv @@
// Top-level testbench for the sprite collision scan unit.
`timescale 1ns / 1ps

module tb_top
  import scs_pkg::*;
  import scs_tb_pkg::*;
();

  localparam int CLK_PERIOD  = 8;
  localparam int N_ITEMS     = 1550;
  // worst case per item: a full query scan, the longest sender gap and a
  // stretch of heavy output stall, plus the single long hold-off; taken
  // several times over
  localparam int CYCLE_LIMIT = 600000;
  // drain window after the last owed answer, longer than a query of an active slot takes
  localparam int DRAIN_CYCLES = 2 * NUM_SLOTS_DEF + 10;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  scs_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  scs_out_t out_data;

  collision_scoreboard sb = new();

  int unsigned cycles;
  int unsigned in_stall_cycles;
  int unsigned out_stall_cycles;
  scs_in_t     directed_q [$];

  sprite_collision_scan_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // Item builders. Queries carry random payload in the unused fields so
  // the don't-care bits toggle as well.
  // ---------------------------------------------------------------------
  function automatic scs_in_t mk_write(int s, int x, int y, int r, bit act);
    scs_in_t it;
    it.req_type   = REQ_WRITE;
    it.slot       = SLOT_W'(s);
    it.pos_x      = COORD_W'(x);
    it.pos_y      = COORD_W'(y);
    it.hit_radius = RADIUS_W'(r);
    it.active     = act;
    return it;
  endfunction

  function automatic scs_in_t mk_query(int s);
    scs_in_t it;
    it.req_type   = REQ_QUERY;
    it.slot       = SLOT_W'(s);
    it.pos_x      = COORD_W'($urandom);
    it.pos_y      = COORD_W'($urandom);
    it.hit_radius = RADIUS_W'($urandom);
    it.active     = 1'($urandom);
    return it;
  endfunction

  // Random traffic: mostly a tight cluster around the origin so that
  // collisions are common, some clusters hugging either end of the
  // coordinate range (where a wrapped difference would give false hits),
  // and some full-range noise.
  function automatic scs_in_t random_item();
    scs_in_t it;
    int      region;
    int      x, y, r;
    region = $urandom_range(0, 9);
    unique case (region)
      0: begin
        x = $urandom_range(0, 65535) - 32768;
        y = $urandom_range(0, 65535) - 32768;
      end
      1: begin
        x = 32767 - $urandom_range(0, 400);
        y = 32767 - $urandom_range(0, 400);
      end
      2: begin
        x = $urandom_range(0, 400) - 32768;
        y = $urandom_range(0, 400) - 32768;
      end
      3: begin
        x = ($urandom_range(0, 1) != 0) ? 32767 - $urandom_range(0, 300)
                                         : $urandom_range(0, 300) - 32768;
        y = $urandom_range(0, 800) - 400;
      end
      default: begin
        x = $urandom_range(0, 800) - 400;
        y = $urandom_range(0, 800) - 400;
      end
    endcase
    r = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 255);
    if ($urandom_range(0, 1) != 0) begin
      it = mk_query($urandom_range(0, NUM_SLOTS_DEF - 1));
    end else begin
      it = mk_write($urandom_range(0, NUM_SLOTS_DEF - 1), x, y, r,
                    $urandom_range(0, 3) != 0);
    end
    return it;
  endfunction

  // Offer one item and hold it until the unit takes the transfer. Valid
  // stays high between back-to-back items; only data moves on.
  task automatic send_item(input scs_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) begin
      in_stall_cycles++;
      @(posedge clk);
    end
    sb.note_transfer(it);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus: reset, directed cases, then random bursts.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int idx;
    int burst;
    int gap;

    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    rst_n     <= 1'b0;
    in_stall_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // query of a slot that has never been made active
    directed_q.push_back(mk_query(0));
    // corners of the coordinate range, largest radius; a 16-bit wrapped
    // difference between these two would look like a collision
    directed_q.push_back(mk_write(0, -32768, -32768, 255, 1'b1));
    directed_q.push_back(mk_write(15, 32767, 32767, 255, 1'b1));
    directed_q.push_back(mk_query(0));
    directed_q.push_back(mk_query(15));
    // distance exactly equal to the summed radii (3-4-5 triangle)
    directed_q.push_back(mk_write(3, 0, 0, 3, 1'b1));
    directed_q.push_back(mk_write(4, 3, 4, 2, 1'b1));
    directed_q.push_back(mk_query(3));
    // one step past the circle, still near slot 4
    directed_q.push_back(mk_write(5, 3, 5, 2, 1'b1));
    directed_q.push_back(mk_query(5));
    // both axes inside the box but the diagonal outside the circle
    directed_q.push_back(mk_write(6, 100, 100, 0, 1'b1));
    directed_q.push_back(mk_write(7, 104, 104, 5, 1'b1));
    directed_q.push_back(mk_query(7));
    // zero radii at the same point still touch
    directed_q.push_back(mk_write(8, 100, 100, 0, 1'b1));
    directed_q.push_back(mk_query(8));
    // big radius: several candidates, lowest index wins
    directed_q.push_back(mk_write(9, 100, 100, 255, 1'b1));
    directed_q.push_back(mk_query(9));
    // deactivate a slot, then query it and a former partner
    directed_q.push_back(mk_write(6, 100, 100, 0, 1'b0));
    directed_q.push_back(mk_query(6));
    directed_q.push_back(mk_query(8));
    // exact reach of 510 along one axis at the low corner
    directed_q.push_back(mk_write(10, -32258, -32768, 255, 1'b1));
    directed_q.push_back(mk_query(10));
    // hit reported from the top slot index
    directed_q.push_back(mk_write(11, 32467, 32767, 100, 1'b1));
    directed_q.push_back(mk_query(11));

    idx = 0;
    while (idx < N_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && idx < N_ITEMS; k++) begin
        send_item((idx < directed_q.size()) ? directed_q[idx] : random_item());
        idx++;
      end
      // a quarter of bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // wait for every owed answer, then watch for strays
    while (sb.pending_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d writes and %0d queries (%0d hits, %0d misses) in %0d cycles.",
             sb.n_write, sb.n_query, sb.n_hit, sb.n_query - sb.n_hit, cycles);
    $display("Input held off %0d cycles, output stalled %0d cycles; %0d mismatches.",
             in_stall_cycles, out_stall_cycles, sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: check each accepted transfer, then pick the next stall.
  // The stall pattern switches between free flow, light and heavy stalling
  // in stretches of random length. Once, after 150 answers, it holds the
  // output off so the unit backs up and stalls its input while the sender
  // keeps offering.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    bit hold_done;

    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall_cycles = 0;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_answer(out_data);
      end
      if (out_stall) begin
        out_stall_cycles++;
      end
      if (!hold_done && sb.n_checked >= 150) begin
        hold_left = 500;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 120);
        end
        mode_left--;
        unique case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Cycle counter doubling as the run's watchdog.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d answers owed.",
             cycles, sb.pending_answers.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/scs_pkg.sv
sv/scs_ram.sv
sv/sprite_collision_scan_unit.sv
tb/sv/scs_tb_pkg.sv
tb/sv/tb_top.sv
